>>> rtl/zero_one_knapsack_select_core_defines.svh
// ----------------------------------------------------------------------------
// Knapsack select core assertion macros
// Shared concurrent check forms, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef ZERO_ONE_KNAPSACK_SELECT_CORE_DEFINES_SVH
`define ZERO_ONE_KNAPSACK_SELECT_CORE_DEFINES_SVH

// same-cycle implication
`define ZOKS_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ZOKS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/zoks_pkg.sv
// ----------------------------------------------------------------------------
// Knapsack select package
// Request/result payload types, value widths and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package zoks_pkg;

  localparam int VALUE_W  = 16;
  localparam int WEIGHT_W = 16;
  localparam int CAP_W    = 10;
  localparam int BEST_W   = 22;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;

  localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

  typedef struct packed {
    logic [VALUE_W-1:0]  item_value;
    logic [WEIGHT_W-1:0] item_weight;
    logic                last_item;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] taken_index;
    logic [COUNT_W-1:0] taken_count;
    logic               none_taken;
    logic               last_result;
  } out_item_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SWEEP   = 6'b000010,
    ST_FINISH  = 6'b000100,
    ST_TB_RD   = 6'b001000,
    ST_TB_EVAL = 6'b010000,
    ST_TB_END  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/zoks_ram.sv
// ----------------------------------------------------------------------------
// Knapsack select simple dual-port RAM
// One write port, one registered read port; contents undefined after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module zoks_ram #(
  parameter int AW = 6,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/zoks_row_ram.sv
// ----------------------------------------------------------------------------
// Knapsack select best-value row RAM
// One write port, two registered read ports (slot and slot minus weight).
// ----------------------------------------------------------------------------
`default_nettype none

module zoks_row_ram
  import zoks_pkg::*;
#(
  parameter int AW = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [BEST_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr_a,
  input  wire logic [AW-1:0]     raddr_b,
  output logic      [BEST_W-1:0] rdata_a,
  output logic      [BEST_W-1:0] rdata_b
);

  logic [BEST_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> rtl/zero_one_knapsack_select_core.sv
// ----------------------------------------------------------------------------
// Zero-one knapsack select core
// Each item sweeps the row RAM one row slot per cycle, top slot down to slot 1; in_stall holds off the next item.
// Traceback after the last item reads then evaluates each stored item in turn, and out_stall can hold it.
// Reset clears control and capacity; the row reads as zero on each set's first item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "zero_one_knapsack_select_core_defines.svh"

module zero_one_knapsack_select_core
  import zoks_pkg::*;
#(
  parameter int MAX_ITEMS      = 64,
  parameter int CAPACITY_SLOTS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item,
  // capacity register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_capacity
);

  localparam int SW = $clog2(CAPACITY_SLOTS);
  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [SW-1:0] SLOT_TOP = SW'(CAPACITY_SLOTS - 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  // control
  state_t             state_r,      state_nxt;
  logic [CAP_W-1:0]   cap_r,        cap_nxt;
  logic [CW-1:0]      count_r,      count_nxt;
  logic               p1_valid_r,   p1_valid_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic               out_valid_r,  out_valid_nxt;
  // payload
  logic [VALUE_W-1:0]  val_r,        val_nxt;
  logic [WEIGHT_W-1:0] wt_r,         wt_nxt;
  logic                load_r,       load_nxt;
  logic                last_r,       last_nxt;
  logic                first_r,      first_nxt;
  logic [SW-1:0]       slot_r,       slot_nxt;
  logic [SW-1:0]       p1_slot_r,    p1_slot_nxt;
  logic                p1_ok_r,      p1_ok_nxt;
  logic [CW-1:0]       rem_r,        rem_nxt;
  logic [SW-1:0]       c_r,          c_nxt;
  logic [CW-1:0]       n_r,          n_nxt;
  logic [INDEX_W-1:0]  pend_index_r, pend_index_nxt;
  logic [COUNT_W-1:0]  pend_count_r, pend_count_nxt;
  out_item_t           out_item_r,   out_item_nxt;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic [SW-1:0]       row_raddr_b;
  logic [BEST_W-1:0]   row_rd_a, row_rd_b, row_wdata;
  logic                take_bit;
  logic [CW-1:0]       tb_k;
  logic [0:0]          take_q;
  logic [WEIGHT_W-1:0] wt_q;
  logic                in_accept;

  assign in_accept = in_valid && !in_stall;
  assign tb_k      = rem_r - CW'(1);

  // best value per slot, rewritten at every slot but slot 0 by every stored item
  zoks_row_ram #(.AW(SW)) u_row_ram (
    .clk     (clk),
    .we      (p1_valid_r),
    .waddr   (p1_slot_r),
    .wdata   (row_wdata),
    .raddr_a (slot_r),
    .raddr_b (row_raddr_b),
    .rdata_a (row_rd_a),
    .rdata_b (row_rd_b)
  );

  // take bit per (item, slot); read one at a time during traceback
  zoks_ram #(.AW(IW + SW), .DW(1)) u_take_ram (
    .clk   (clk),
    .we    (p1_valid_r),
    .waddr ({count_r[IW-1:0], p1_slot_r}),
    .wdata (take_bit),
    .raddr ({tb_k[IW-1:0], c_r}),
    .rdata (take_q)
  );

  // per-item weight for the traceback capacity walk
  zoks_ram #(.AW(IW), .DW(WEIGHT_W)) u_wt_ram (
    .clk   (clk),
    .we    (in_accept && (32'(count_r) < MAX_ITEMS)),
    .waddr (count_r[IW-1:0]),
    .wdata (in_item.item_weight),
    .raddr (tb_k[IW-1:0]),
    .rdata (wt_q)
  );

  // --------------------------------------------------------------------------
  // Row update stage: read data for p1_slot_r arrives here.
  // The first item of a set sees an all-zero row, which stands in for clearing.
  // --------------------------------------------------------------------------
  logic [BEST_W-1:0] best_old, best_base, cand;
  logic [BEST_W:0]   cand_sum;

  always_comb begin
    best_old  = first_r ? '0 : row_rd_a;
    // slot 0 is never written, so a weight equal to the slot takes zero as its base
    best_base = (first_r || (32'(wt_r) == 32'(p1_slot_r))) ? '0 : row_rd_b;
    cand_sum  = {1'b0, best_base} + (BEST_W + 1)'(val_r);
    cand      = cand_sum[BEST_W] ? BEST_MAX : cand_sum[BEST_W-1:0];
    take_bit  = p1_ok_r && (cand > best_old);
    row_wdata = take_bit ? cand : best_old;
  end

  // slot minus weight; only meaningful when the weight fits
  assign row_raddr_b = slot_r - SW'(wt_r);

  // --------------------------------------------------------------------------
  // Traceback helpers
  // --------------------------------------------------------------------------
  logic [SW-1:0] cap_slot, c_after;
  logic          tb_hit, out_free;

  assign cap_slot = (32'(cap_r) > (CAPACITY_SLOTS - 1)) ? SLOT_TOP : SW'(cap_r);
  // slot zero never takes anything
  assign tb_hit   = take_q[0] && (c_r != '0);
  assign c_after  = (32'(wt_q) <= 32'(c_r)) ? (c_r - SW'(wt_q)) : '0;
  assign out_free = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = (cfg_valid && cfg_ready) ? cfg_capacity : cap_r;
    count_nxt      = count_r;
    p1_valid_nxt   = 1'b0;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    val_nxt        = val_r;
    wt_nxt         = wt_r;
    load_nxt       = load_r;
    last_nxt       = last_r;
    first_nxt      = first_r;
    slot_nxt       = slot_r;
    p1_slot_nxt    = slot_r;
    p1_ok_nxt      = 32'(wt_r) <= 32'(slot_r);
    rem_nxt        = rem_r;
    c_nxt          = c_r;
    n_nxt          = n_r;
    pend_index_nxt = pend_index_r;
    pend_count_nxt = pend_count_r;
    out_item_nxt   = out_item_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          val_nxt   = in_item.item_value;
          wt_nxt    = in_item.item_weight;
          last_nxt  = in_item.last_item;
          load_nxt  = 32'(count_r) < MAX_ITEMS;
          first_nxt = count_r == '0;
          slot_nxt  = SLOT_TOP;
          // items past the store limit only count for their last mark
          state_nxt = (32'(count_r) < MAX_ITEMS) ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        p1_valid_nxt = 1'b1;
        if (slot_r == SW'(1)) begin
          state_nxt = ST_FINISH;
        end else begin
          slot_nxt = slot_r - SW'(1);
        end
      end
      ST_FINISH: begin
        // slot 1 write-back happens this cycle
        count_nxt = load_r ? (count_r + CW'(1)) : count_r;
        if (last_r) begin
          rem_nxt   = count_nxt;
          c_nxt     = cap_slot;
          n_nxt     = '0;
          state_nxt = (count_nxt == '0) ? ST_TB_END : ST_TB_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TB_RD: begin
        state_nxt = ST_TB_EVAL;
      end
      ST_TB_EVAL: begin
        // the newest hit is held back so the final one can carry last_result
        if (!(tb_hit && pend_valid_r && !out_free)) begin
          if (tb_hit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{taken_index: pend_index_r, taken_count: pend_count_r,
                                none_taken: 1'b0, last_result: 1'b0};
            end
            pend_valid_nxt = 1'b1;
            pend_index_nxt = INDEX_W'(tb_k);
            pend_count_nxt = COUNT_W'(n_r + CW'(1));
            n_nxt          = n_r + CW'(1);
            c_nxt          = c_after;
          end
          rem_nxt   = rem_r - CW'(1);
          state_nxt = (rem_r == CW'(1)) ? ST_TB_END : ST_TB_RD;
        end
      end
      ST_TB_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_item_nxt = '{taken_index: pend_index_r, taken_count: pend_count_r,
                             none_taken: 1'b0, last_result: 1'b1};
          end else begin
            out_item_nxt = '{taken_index: '0, taken_count: '0,
                             none_taken: 1'b1, last_result: 1'b1};
          end
          pend_valid_nxt = 1'b0;
          count_nxt      = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= '0;
      count_r      <= '0;
      p1_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cap_r        <= cap_nxt;
      count_r      <= count_nxt;
      p1_valid_r   <= p1_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r        <= val_nxt;
    wt_r         <= wt_nxt;
    load_r       <= load_nxt;
    last_r       <= last_nxt;
    first_r      <= first_nxt;
    slot_r       <= slot_nxt;
    p1_slot_r    <= p1_slot_nxt;
    p1_ok_r      <= p1_ok_nxt;
    rem_r        <= rem_nxt;
    c_r          <= c_nxt;
    n_r          <= n_nxt;
    pend_index_r <= pend_index_nxt;
    pend_count_r <= pend_count_nxt;
    out_item_r   <= out_item_nxt;
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `ZOKS_CHECK(a_p1_in_sweep, p1_valid_r, state_r == ST_SWEEP || state_r == ST_FINISH, "row write outside sweep")
  `ZOKS_CHECK(a_count_max, 1'b1, 32'(count_r) <= MAX_ITEMS, "item count above limit")
  `ZOKS_CHECK(a_idle_no_pend, state_r == ST_IDLE, !pend_valid_r, "held result left over in idle")
  `ZOKS_CHECK(a_none_shape, out_valid_r && out_item_r.none_taken, out_item_r.last_result && out_item_r.taken_count == '0, "bad empty answer")
  `ZOKS_CHECK_NEXT(a_set_done, state_r == ST_TB_END && out_free, state_r == ST_IDLE && count_r == '0, "set not closed")

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Knapsack select core testbench
// Feeds item sets through the request channel under several capacity
// settings and idle/stall patterns. A behavioral copy of the dp row, the take
// bits and the traceback predicts the picks of each set, and every result is
// checked in order against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zoks_pkg::*;

  localparam int MAX_ITEMS      = 64;
  localparam int CAPACITY_SLOTS = 1024;
  // one full row sweep plus margin; covers any in-flight item with no result
  localparam int SETTLE_CYCLES  = CAPACITY_SLOTS + 64;
  localparam int SEG_ITEMS      = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  in_item_t         in_item      = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_capacity = '0;

  zero_one_knapsack_select_core #(
    .MAX_ITEMS      (MAX_ITEMS),
    .CAPACITY_SLOTS (CAPACITY_SLOTS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shared testbench state
  // --------------------------------------------------------------------------
  in_item_t  request_q[$];     // requests waiting to be driven
  out_item_t expected_picks[$]; // predicted results, oldest first
  int        bad_count    = 0;
  int        seg_items    = 0;
  int        send_gap_pct = 0;   // chance per cycle that the sender holds off
  int        recv_stall_pct = 0; // chance per cycle that the receiver stalls
  bit        req_taken    = 1'b0;
  bit        cfg_done     = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor state: dp row, per-item take bits, stored weights, capacity
  // --------------------------------------------------------------------------
  logic [BEST_W-1:0]         best_row [CAPACITY_SLOTS];
  bit [CAPACITY_SLOTS-1:0]   take_row [MAX_ITEMS];
  logic [WEIGHT_W-1:0]       kept_weight [MAX_ITEMS];
  int                        kept_count;
  logic [CAP_W-1:0]          capacity_reg = '0;

  // start of a new set: row back to zero, no items stored
  task automatic clear_set();
    foreach (best_row[j]) best_row[j] = '0;
    kept_count = 0;
  endtask

  // Folds one accepted request into the row; on the last item of a set it
  // walks the take bits back from the capacity slot and queues the picks.
  task automatic knapsack_step(input in_item_t req);
    logic [BEST_W:0] cand;
    int              slot;
    int              hits[$];
    out_item_t       pick;
    // items past the first MAX_ITEMS are dropped but still may end the set
    if (kept_count < MAX_ITEMS) begin
      kept_weight[kept_count] = req.item_weight;
      take_row[kept_count] = '0;
      // slot 0 never changes; sweep high to low so the row is reused in place
      for (int j = CAPACITY_SLOTS - 1; j >= 1; j--) begin
        if (req.item_weight <= j) begin
          cand = best_row[j - req.item_weight] + req.item_value;
          if (cand > BEST_MAX) cand = BEST_MAX;
          // strictly better only: ties keep the earlier choice
          if (cand > best_row[j]) begin
            best_row[j] = cand[BEST_W-1:0];
            take_row[kept_count][j] = 1'b1;
          end
        end
      end
      kept_count++;
    end
    if (!req.last_item) return;

    slot = (capacity_reg > CAPACITY_SLOTS - 1) ? CAPACITY_SLOTS - 1 : int'(capacity_reg);
    for (int k = kept_count - 1; k >= 0; k--) begin
      if (take_row[k][slot]) begin
        hits.insert(hits.size(), k);
        slot = (kept_weight[k] <= slot) ? slot - kept_weight[k] : 0;
      end
    end

    if (hits.size() == 0) begin
      pick.taken_index = '0;
      pick.taken_count = '0;
      pick.none_taken  = 1'b1;
      pick.last_result = 1'b1;
      expected_picks.insert(expected_picks.size(), pick);
    end else begin
      foreach (hits[i]) begin
        pick.taken_index = INDEX_W'(hits[i]);
        pick.taken_count = COUNT_W'(i + 1);
        pick.none_taken  = 1'b0;
        pick.last_result = (i == hits.size() - 1);
        expected_picks.insert(expected_picks.size(), pick);
      end
    end
    clear_set();
  endtask

  // --------------------------------------------------------------------------
  // Request driver: changes on the falling edge, holds while stalled
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      // a request still waiting keeps valid and payload untouched
      if (!in_valid || req_taken) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_item  <= request_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: handshakes sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        capacity_reg = cfg_capacity;
        cfg_done = 1'b1;
      end

      if (in_valid && !in_stall) begin
        knapsack_step(in_item);
        void'(request_q.pop_front());
        req_taken = 1'b1;
      end

      if (out_valid && !out_stall) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected result: index %0d count %0d none %0b last %0b",
                   $time, out_item.taken_index, out_item.taken_count,
                   out_item.none_taken, out_item.last_result);
          bad_count++;
        end else begin
          want = expected_picks.pop_front();
          if (out_item !== want) begin
            $display("%0t: mismatch: expected index %0d count %0d none %0b last %0b",
                     $time, want.taken_index, want.taken_count,
                     want.none_taken, want.last_result);
            $display("%0t:           actual   index %0d count %0d none %0b last %0b",
                     $time, out_item.taken_index, out_item.taken_count,
                     out_item.none_taken, out_item.last_result);
            bad_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_request(input logic [VALUE_W-1:0] v, input logic [WEIGHT_W-1:0] w,
                               input bit last);
    in_item_t req;
    req.item_value  = v;
    req.item_weight = w;
    req.last_item   = last;
    request_q.insert(request_q.size(), req);
    seg_items++;
  endtask

  // wait for every request and result to go through, then let the core settle
  task automatic drain_block();
    while (request_q.size() != 0 || expected_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_done = 1'b0;
    cfg_capacity <= v;
    cfg_valid    <= 1'b1;
    while (!cfg_done) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // capacity and idling only change with the core idle
  task automatic start_segment(input int cap, input idle_mode_t mode);
    drain_block();
    write_capacity(CAP_W'(cap));
    case (mode)
      IDLE_SENDER: begin
        send_gap_pct = 75; recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0; recv_stall_pct = 75;
      end
      IDLE_BOTH: begin
        send_gap_pct = 33; recv_stall_pct = 33;
      end
      default: begin
        send_gap_pct = 0; recv_stall_pct = 0;
      end
    endcase
    seg_items = 0;
  endtask

  // one set: mostly small weights that fit, some zero and full-range weights
  task automatic queue_random_set(input int cap);
    int                  n;
    int                  span;
    int                  r;
    logic [VALUE_W-1:0]  v;
    logic [WEIGHT_W-1:0] w;
    n    = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
    span = (cap * 2) / 3 + 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 10)      w = '0;
      else if (r < 22) w = WEIGHT_W'($urandom);
      else             w = WEIGHT_W'($urandom_range(1, span));
      r = $urandom_range(99);
      if (r < 8)       v = '0;
      else if (r < 14) v = '1;
      else             v = VALUE_W'($urandom_range(0, 65535));
      queue_request(v, w, i == n - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int cap;
    clear_set();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: full capacity, field extremes
    start_segment(1023, IDLE_NONE);
    queue_request(16'h0000, 16'h0000, 1'b1); // zero value never taken
    queue_request(16'hFFFF, 16'h0000, 1'b1); // zero weight, taken
    queue_request(16'hFFFF, 16'hFFFF, 1'b1); // weight beyond every slot
    queue_request(16'h0001, 16'd1023, 1'b1); // exactly fills the knapsack
    queue_request(16'h0009, 16'd1024, 1'b1); // one past the top slot
    queue_request(16'd10, 16'd5, 1'b0);
    queue_request(16'd20, 16'd6, 1'b0);
    queue_request(16'd15, 16'd5, 1'b0);
    queue_request(16'd7,  16'd3, 1'b1);      // all four fit

    // directed: zero capacity, slot 0 never takes anything
    start_segment(0, IDLE_NONE);
    queue_request(16'd5, 16'd0, 1'b1);
    queue_request(16'd5, 16'd1, 1'b0);
    queue_request(16'd7, 16'd0, 1'b1);

    // directed: small capacity, ties and real choices
    start_segment(10, IDLE_NONE);
    queue_request(16'd100, 16'd10, 1'b0);
    queue_request(16'd100, 16'd10, 1'b1);    // tie keeps the first item
    queue_request(16'd60, 16'd4, 1'b0);
    queue_request(16'd50, 16'd3, 1'b0);
    queue_request(16'd70, 16'd5, 1'b0);
    queue_request(16'd30, 16'd2, 1'b1);
    queue_request(16'hFFFF, 16'd0, 1'b0);
    queue_request(16'h5555, 16'hAAAA, 1'b0);
    queue_request(16'h8000, 16'd10, 1'b1);

    // random sets over every idle pattern, two capacities each
    for (int s = 0; s < 8; s++) begin
      case (s % 4)
        0:       cap = 1023;
        1:       cap = $urandom_range(1, 40);
        2:       cap = $urandom_range(41, 1022);
        default: cap = $urandom_range(0, 1023);
      endcase
      start_segment(cap, idle_mode_t'(s / 2));
      // overfull set: every item weightless, extra items past the limit dropped
      if (s == 5) begin
        for (int i = 0; i < MAX_ITEMS + 2; i++)
          queue_request(VALUE_W'($urandom_range(1, 65535)), '0, i == MAX_ITEMS + 1);
      end
      while (seg_items < SEG_ITEMS) queue_random_set(cap);
    end

    drain_block();
    if (bad_count == 0 && expected_picks.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/zoks_pkg.sv
rtl/zoks_ram.sv
rtl/zoks_row_ram.sv
rtl/zero_one_knapsack_select_core.sv
test/tb.sv
